FILE: rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge out of reset.
`define AAC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Condition must never be true out of reset.
`define AAC_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

FILE: rtl/aac_pkg.sv
// Shared widths and stage payload types for the box/circle contact pipeline.
package aac_pkg;

	localparam int IN_W   = 24;          // signed coordinate
	localparam int EXT_W  = 23;          // unsigned extent / radius
	localparam int N_W    = 27;          // offsets in half-LSB units
	localparam int MAG_W  = 26;          // magnitude of a contact vector component
	localparam int D2_W   = 54;          // squared distance
	localparam int LEN_W  = D2_W / 2;    // integer square root
	localparam int RR_W   = 2 * (EXT_W + 1);
	localparam int PEN_W  = 26;
	localparam int NRM_W  = 16;
	localparam int DEF_NORMAL_FRAC_BITS = 14;

	typedef struct packed {
		logic              hit;
		logic              neg_x;
		logic              neg_y;
		logic [MAG_W-1:0]  mx;
		logic [MAG_W-1:0]  my;
		logic [EXT_W:0]    r2;
	} vec_t;

	typedef struct packed {
		logic                    hit;
		logic                    neg_x;
		logic                    neg_y;
		logic                    zero;
		logic signed [PEN_W-1:0] pen;
	} side_t;

endpackage

FILE: rtl/aabb_circle_collision.sv
// Box/circle contact pipeline. Throughput one word per cycle while the skid is empty
// (input ready drops while it holds a result): 4 geometry stages, one stage per root bit
// of the 27-stage square root, one per quotient bit in the divider, one output register.
// A two-entry output (register plus skid) keeps input ready while one result waits.
// arst_n clears all valid bits asynchronously; data registers are not reset.
`include "assert_macros.svh"

module aabb_circle_collision import aac_pkg::*; #(
	parameter int NORMAL_FRAC_BITS = DEF_NORMAL_FRAC_BITS
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// box_x, box_y, box_width, box_height, circle_x, circle_y, radius, 3 pad bits
	input  logic [167:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// normal_x, normal_y, penetration, 6 pad bits
	output logic [63:0]  m_tdata,
	// hit
	output logic         m_tuser
);

	localparam int NFB = NORMAL_FRAC_BITS;

	typedef struct packed {
		logic                    hit;
		logic signed [NRM_W-1:0] nx;
		logic signed [NRM_W-1:0] ny;
		logic signed [PEN_W-1:0] pen;
	} res_t;

	logic en;
	logic skid_v_q, out_v_q;
	res_t skid_q, out_q;

	assign en       = !skid_v_q;
	assign s_tready = en;

	// front end
	logic             g_v;
	vec_t             g_vec;
	logic [D2_W-1:0]  g_d2;

	aac_geom u_geom (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.in_v       (s_tvalid),
		.box_x      ($signed(s_tdata[23:0])),
		.box_y      ($signed(s_tdata[47:24])),
		.box_width  (s_tdata[70:48]),
		.box_height (s_tdata[93:71]),
		.circle_x   ($signed(s_tdata[117:94])),
		.circle_y   ($signed(s_tdata[141:118])),
		.radius     (s_tdata[164:142]),
		.out_v      (g_v),
		.out_vec    (g_vec),
		.out_d2     (g_d2)
	);

	// square root
	logic             r_v;
	logic [LEN_W-1:0] r_len;
	vec_t             r_vec;

	aac_sqrt u_sqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_v    (g_v),
		.in_d2   (g_d2),
		.in_vec  (g_vec),
		.out_v   (r_v),
		.out_len (r_len),
		.out_vec (r_vec)
	);

	// penetration: floor((2r - len) / 2), saturated
	logic signed [LEN_W:0]   pdiff;
	logic signed [LEN_W-1:0] phalf;
	side_t                   d_side_in;

	always_comb begin
		pdiff = $signed({{(LEN_W-EXT_W-1){1'b0}}, r_vec.r2}) - $signed({1'b0, r_len});
		phalf = LEN_W'(pdiff >>> 1);
		d_side_in.hit   = r_vec.hit;
		d_side_in.neg_x = r_vec.neg_x;
		d_side_in.neg_y = r_vec.neg_y;
		d_side_in.zero  = (r_len == '0);
		if (phalf > $signed(LEN_W'(33554431))) begin
			d_side_in.pen = PEN_W'(33554431);
		end else if (phalf < -$signed(LEN_W'(33554432))) begin
			d_side_in.pen = PEN_W'(-33554432);
		end else begin
			d_side_in.pen = PEN_W'(phalf);
		end
	end

	// divider
	logic         d_v;
	logic [NFB:0] d_qx, d_qy;
	side_t        d_side;

	aac_div #(.NFB(NFB)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_v     (r_v),
		.in_mx    (r_vec.mx),
		.in_my    (r_vec.my),
		.in_len   (r_len),
		.in_side  (d_side_in),
		.out_v    (d_v),
		.out_qx   (d_qx),
		.out_qy   (d_qy),
		.out_side (d_side)
	);

	res_t res;

	aac_fmt #(.NFB(NFB)) u_fmt (
		.qx          (d_qx),
		.qy          (d_qy),
		.side        (d_side),
		.hit         (res.hit),
		.normal_x    (res.nx),
		.normal_y    (res.ny),
		.penetration (res.pen)
	);

	// output register with skid
	logic stalled, push, load_res, load_skid, to_skid;

	assign stalled   = out_v_q && !m_tready;
	assign push      = en && d_v;
	assign to_skid   = stalled && push;
	assign load_skid = !stalled && skid_v_q;
	assign load_res  = !stalled && !skid_v_q && push;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else begin
			if (to_skid) begin
				skid_v_q <= 1'b1;
			end else if (load_skid) begin
				skid_v_q <= 1'b0;
			end
			if (!stalled) begin
				out_v_q <= load_skid || load_res;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (to_skid) begin
			skid_q <= res;
		end
		if (load_skid) begin
			out_q <= skid_q;
		end else if (load_res) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tuser  = out_q.hit;
	assign m_tdata  = {6'b0, out_q.pen, out_q.ny, out_q.nx};

	`AAC_ASSERT(a_skid_needs_out, skid_v_q |-> out_v_q, "skid full with empty output word")
	`AAC_ASSERT(a_skid_on_stall, $rose(skid_v_q) |-> $past(out_v_q && !m_tready), "skid filled without stall")
	`AAC_NEVER(a_miss_zero_normal, out_v_q && !out_q.hit && (out_q.nx != 0 || out_q.ny != 0), "normal set on miss")

endmodule

FILE: rtl/aac_geom.sv
// Front end: offsets, clamp and face snap, squares, squared distance and hit test.
module aac_geom import aac_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic                    in_v,
	input  logic signed [IN_W-1:0]  box_x,
	input  logic signed [IN_W-1:0]  box_y,
	input  logic [EXT_W-1:0]        box_width,
	input  logic [EXT_W-1:0]        box_height,
	input  logic signed [IN_W-1:0]  circle_x,
	input  logic signed [IN_W-1:0]  circle_y,
	input  logic [EXT_W-1:0]        radius,
	output logic                    out_v,
	output vec_t                    out_vec,
	output logic [D2_W-1:0]         out_d2
);

	// stage 1: offsets from box center
	logic                   v_s1;
	logic signed [N_W-1:0]  nx_s1, ny_s1;
	logic [EXT_W-1:0]       w_s1, h_s1, r_s1;
	logic signed [N_W-1:0]  nx, ny;

	assign nx = {{2{circle_x[IN_W-1]}}, circle_x, 1'b0}
		- {{2{box_x[IN_W-1]}}, box_x, 1'b0} - {4'b0, box_width};
	assign ny = {{2{circle_y[IN_W-1]}}, circle_y, 1'b0}
		- {{2{box_y[IN_W-1]}}, box_y, 1'b0} - {4'b0, box_height};

	// stage 2: closest point and contact vector
	logic                   v_s2, ins_s2;
	logic signed [N_W-1:0]  vx_s2, vy_s2;
	logic [EXT_W-1:0]       r_s2;
	logic signed [N_W-1:0]  wp, wn, hp, hn, px, py, vx, vy;
	logic [N_W-1:0]         ax, ay;
	logic                   in_box;

	always_comb begin
		wp = {4'b0, w_s1};
		wn = -wp;
		hp = {4'b0, h_s1};
		hn = -hp;
		px = (nx_s1 < wn) ? wn : ((nx_s1 > wp) ? wp : nx_s1);
		py = (ny_s1 < hn) ? hn : ((ny_s1 > hp) ? hp : ny_s1);
		in_box = (nx_s1 >= wn) && (nx_s1 <= wp) && (ny_s1 >= hn) && (ny_s1 <= hp);
		ax = nx_s1[N_W-1] ? N_W'(-nx_s1) : N_W'(nx_s1);
		ay = ny_s1[N_W-1] ? N_W'(-ny_s1) : N_W'(ny_s1);
		if (in_box) begin
			// snap to nearest face; ties go to y
			if (ax > ay) begin
				px = (nx_s1 > 0) ? wp : wn;
			end else begin
				py = (ny_s1 > 0) ? hp : hn;
			end
		end
		vx = nx_s1 - px;
		vy = ny_s1 - py;
	end

	// stage 3: squares and magnitudes
	logic                   v_s3, ins_s3;
	logic [D2_W-1:0]        sqx_s3, sqy_s3;
	logic [RR_W-1:0]        rr_s3;
	vec_t                   vec_s3;
	logic signed [2*N_W-1:0] sqx, sqy;
	logic [EXT_W:0]         r2;

	assign sqx = vx_s2 * vx_s2;
	assign sqy = vy_s2 * vy_s2;
	assign r2  = {r_s2, 1'b0};

	// stage 4: squared distance and hit
	logic                   v_s4;
	vec_t                   vec_s4;
	logic [D2_W-1:0]        d2_s4;
	logic [D2_W-1:0]        d2;

	assign d2 = sqx_s3 + sqy_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_v;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nx_s1  <= nx;
			ny_s1  <= ny;
			w_s1   <= box_width;
			h_s1   <= box_height;
			r_s1   <= radius;

			vx_s2  <= vx;
			vy_s2  <= vy;
			ins_s2 <= in_box;
			r_s2   <= r_s1;

			sqx_s3 <= D2_W'(sqx);
			sqy_s3 <= D2_W'(sqy);
			rr_s3  <= r2 * r2;
			ins_s3 <= ins_s2;
			vec_s3.mx    <= vx_s2[N_W-1] ? MAG_W'(-vx_s2) : MAG_W'(vx_s2);
			vec_s3.my    <= vy_s2[N_W-1] ? MAG_W'(-vy_s2) : MAG_W'(vy_s2);
			// normal is flipped when the center is inside
			vec_s3.neg_x <= ins_s2 ? (vx_s2 > 0) : vx_s2[N_W-1];
			vec_s3.neg_y <= ins_s2 ? (vy_s2 > 0) : vy_s2[N_W-1];
			vec_s3.r2    <= r2;

			d2_s4        <= d2;
			vec_s4.hit   <= ins_s3 || (d2 <= {{(D2_W-RR_W){1'b0}}, rr_s3});
			vec_s4.neg_x <= vec_s3.neg_x;
			vec_s4.neg_y <= vec_s3.neg_y;
			vec_s4.mx    <= vec_s3.mx;
			vec_s4.my    <= vec_s3.my;
			vec_s4.r2    <= vec_s3.r2;
		end
	end

	assign out_v   = v_s4;
	assign out_vec = vec_s4;
	assign out_d2  = d2_s4;

endmodule

FILE: rtl/aac_sqrt.sv
// Pipelined integer square root, one result bit per stage.
module aac_sqrt import aac_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_v,
	input  logic [D2_W-1:0]  in_d2,
	input  vec_t             in_vec,
	output logic             out_v,
	output logic [LEN_W-1:0] out_len,
	output vec_t             out_vec
);

	localparam int NS    = LEN_W;
	localparam int REM_W = LEN_W + 1;

	logic              v_s   [NS];
	logic [D2_W-1:0]   x_s   [NS];
	logic [REM_W-1:0]  rem_s [NS];
	logic [LEN_W-1:0]  root_s[NS];
	vec_t              vec_s [NS];

	for (genvar i = 0; i < NS; i++) begin : g_st
		logic              v_in;
		logic [D2_W-1:0]   x_in;
		logic [REM_W-1:0]  r_in;
		logic [LEN_W-1:0]  q_in;
		vec_t              s_in;
		logic [REM_W+1:0]  cur, trial;
		logic              take;

		if (i == 0) begin : g_first
			assign v_in = in_v;
			assign x_in = in_d2;
			assign r_in = '0;
			assign q_in = '0;
			assign s_in = in_vec;
		end else begin : g_next
			assign v_in = v_s[i-1];
			assign x_in = x_s[i-1];
			assign r_in = rem_s[i-1];
			assign q_in = root_s[i-1];
			assign s_in = vec_s[i-1];
		end

		assign cur   = {r_in, x_in[D2_W-1 -: 2]};
		assign trial = {1'b0, q_in, 2'b01};
		assign take  = cur >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i] <= 1'b0;
			end else if (en) begin
				v_s[i] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				x_s[i]    <= x_in << 2;
				rem_s[i]  <= take ? REM_W'(cur - trial) : REM_W'(cur);
				root_s[i] <= {q_in[LEN_W-2:0], take};
				vec_s[i]  <= s_in;
			end
		end
	end

	assign out_v   = v_s[NS-1];
	assign out_len = root_s[NS-1];
	assign out_vec = vec_s[NS-1];

endmodule

FILE: rtl/aac_div.sv
// Two-lane pipelined restoring divider for the normal components.
module aac_div import aac_pkg::*; #(
	parameter int NFB = DEF_NORMAL_FRAC_BITS
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_v,
	input  logic [MAG_W-1:0] in_mx,
	input  logic [MAG_W-1:0] in_my,
	input  logic [LEN_W-1:0] in_len,
	input  side_t            in_side,
	output logic             out_v,
	output logic [NFB:0]     out_qx,
	output logic [NFB:0]     out_qy,
	output side_t            out_side
);

	localparam int QB = NFB + 1;
	localparam int DW = MAG_W + NFB + 1;

	logic              v_s   [QB];
	logic [DW-1:0]     rx_s  [QB];
	logic [DW-1:0]     ry_s  [QB];
	logic [QB-1:0]     qx_s  [QB];
	logic [QB-1:0]     qy_s  [QB];
	logic [LEN_W-1:0]  len_s [QB];
	side_t             side_s[QB];

	// rounded dividend: |v| * 2^NFB + len/2
	logic [DW-1:0] magx, magy;
	assign magx = {1'b0, in_mx, {NFB{1'b0}}} + DW'(in_len >> 1);
	assign magy = {1'b0, in_my, {NFB{1'b0}}} + DW'(in_len >> 1);

	for (genvar i = 0; i < QB; i++) begin : g_st
		logic              v_in;
		logic [DW-1:0]     rx_in, ry_in, dsh;
		logic [QB-1:0]     qx_in, qy_in;
		logic [LEN_W-1:0]  l_in;
		side_t             s_in;
		logic              tx, ty;

		if (i == 0) begin : g_first
			assign v_in  = in_v;
			assign rx_in = magx;
			assign ry_in = magy;
			assign qx_in = '0;
			assign qy_in = '0;
			assign l_in  = in_len;
			assign s_in  = in_side;
		end else begin : g_next
			assign v_in  = v_s[i-1];
			assign rx_in = rx_s[i-1];
			assign ry_in = ry_s[i-1];
			assign qx_in = qx_s[i-1];
			assign qy_in = qy_s[i-1];
			assign l_in  = len_s[i-1];
			assign s_in  = side_s[i-1];
		end

		assign dsh = DW'(l_in) << (QB - 1 - i);
		assign tx  = rx_in >= dsh;
		assign ty  = ry_in >= dsh;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i] <= 1'b0;
			end else if (en) begin
				v_s[i] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rx_s[i]   <= tx ? rx_in - dsh : rx_in;
				ry_s[i]   <= ty ? ry_in - dsh : ry_in;
				qx_s[i]   <= {qx_in[QB-2:0], tx};
				qy_s[i]   <= {qy_in[QB-2:0], ty};
				len_s[i]  <= l_in;
				side_s[i] <= s_in;
			end
		end
	end

	assign out_v    = v_s[QB-1];
	assign out_qx   = qx_s[QB-1];
	assign out_qy   = qy_s[QB-1];
	assign out_side = side_s[QB-1];

endmodule

FILE: rtl/aac_top_dummy_placeholder.sv
// Output formatting stage: sign, saturation and hit/zero-length gating of the normal.
module aac_fmt import aac_pkg::*; #(
	parameter int NFB = DEF_NORMAL_FRAC_BITS
) (
	input  logic [NFB:0]             qx,
	input  logic [NFB:0]             qy,
	input  side_t                    side,
	output logic                     hit,
	output logic signed [NRM_W-1:0]  normal_x,
	output logic signed [NRM_W-1:0]  normal_y,
	output logic signed [PEN_W-1:0]  penetration
);

	localparam int QB = NFB + 1;

	function automatic logic signed [NRM_W-1:0] sat_nrm(input logic [QB-1:0] q,
			input logic neg);
		logic signed [QB:0] sv;
		logic signed [31:0] wv;
		sv = neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
		wv = 32'(sv);
		if (wv > 32'sd32767) begin
			wv = 32'sd32767;
		end else if (wv < -32'sd32768) begin
			wv = -32'sd32768;
		end
		return NRM_W'(wv);
	endfunction

	logic keep;
	assign keep        = side.hit && !side.zero;
	assign hit         = side.hit;
	assign normal_x    = keep ? sat_nrm(qx, side.neg_x) : '0;
	assign normal_y    = keep ? sat_nrm(qy, side.neg_y) : '0;
	assign penetration = side.pen;

endmodule
